/* hw/rtl/assert_macros.svh */
// Assertion helpers; the synthesis build sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising clock edge outside reset.
`define PBR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pbr assertion failed");

// Check that a condition never holds outside reset.
`define PBR_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pbr forbidden condition seen");

`else

`define PBR_ASSERT(lbl, clk, rst_n, prop)
`define PBR_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* hw/rtl/pbr_pkg.sv */
package pbr_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = SLOT_W + 1;
    localparam int PAGE_W   = 32;
    localparam int AGE_W    = 5;
    localparam int OSLOT_W  = 4;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(31);

    // Commands from the request sequencer to the age store.
    typedef struct packed {
        logic              fill_we;
        logic [SLOT_W-1:0] fill_idx;
        logic              scan_start;
    } age_cmd_t;

    // Status from the age store back to the sequencer.
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] victim;
    } age_sts_t;

endpackage

/* hw/rtl/pbr_age_scan.sv */
`include "assert_macros.svh"

module pbr_age_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  pbr_pkg::age_cmd_t cmd,
    output pbr_pkg::age_sts_t sts
);

    logic [pbr_pkg::AGE_W-1:0] age_mem [pbr_pkg::SLOTS];
    logic [pbr_pkg::AGE_W-1:0] age_rd_reg;

    logic                       scan_on_reg, scan_on_next;
    logic [pbr_pkg::SLOT_W-1:0] cnt_reg, cnt_next;
    logic                       pend_reg, pend_next;
    logic [pbr_pkg::SLOT_W-1:0] pend_idx_reg, pend_idx_next;
    logic [pbr_pkg::AGE_W-1:0]  best_reg, best_next;
    logic [pbr_pkg::SLOT_W-1:0] victim_reg, victim_next;
    logic                       zero_reg, zero_next;

    logic [pbr_pkg::AGE_W-1:0]  age_inc;
    logic                       we;
    logic [pbr_pkg::SLOT_W-1:0] waddr;
    logic [pbr_pkg::AGE_W-1:0]  wdata;

    localparam logic [pbr_pkg::SLOT_W-1:0] LAST_IDX = pbr_pkg::SLOT_W'(pbr_pkg::SLOTS - 1);

    assign age_inc = (age_rd_reg < pbr_pkg::AGE_MAX) ? age_rd_reg + 1'b1 : age_rd_reg;

    always_comb begin
        scan_on_next  = scan_on_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        best_next     = best_reg;
        victim_next   = victim_reg;
        zero_next     = 1'b0;

        if (cmd.scan_start) begin
            scan_on_next = 1'b1;
            cnt_next     = '0;
        end else if (scan_on_reg) begin
            pend_next     = 1'b1;
            pend_idx_next = cnt_reg;
            if (cnt_reg == LAST_IDX) begin
                scan_on_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        // Keep the first slot holding the largest age seen so far.
        if (pend_reg) begin
            if (pend_idx_reg == '0 || age_rd_reg > best_reg) begin
                best_next   = age_rd_reg;
                victim_next = pend_idx_reg;
            end
            if (pend_idx_reg == LAST_IDX) begin
                zero_next = 1'b1;
            end
        end
    end

    // At most one write per cycle: fill, aging pass, or victim clear.
    always_comb begin
        we    = 1'b0;
        waddr = cmd.fill_idx;
        wdata = '0;
        if (cmd.fill_we) begin
            we = 1'b1;
        end else if (pend_reg) begin
            we    = 1'b1;
            waddr = pend_idx_reg;
            wdata = age_inc;
        end else if (zero_reg) begin
            we    = 1'b1;
            waddr = victim_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            age_mem[waddr] <= wdata;
        end
        age_rd_reg <= age_mem[cnt_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_on_reg <= 1'b0;
            pend_reg    <= 1'b0;
            zero_reg    <= 1'b0;
        end else begin
            scan_on_reg <= scan_on_next;
            pend_reg    <= pend_next;
            zero_reg    <= zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        pend_idx_reg <= pend_idx_next;
        best_reg     <= best_next;
        victim_reg   <= victim_next;
    end

    assign sts.done   = zero_reg;
    assign sts.victim = victim_reg;

endmodule

/* hw/rtl/page_buffer_pool_replacement.sv */
// Page buffer pool with least-recently-replaced eviction. Each transfer on
// the slave side carries a 32-bit page number; one transfer comes back on
// the master side with the slot that now holds the page, a hit flag, a
// write-back flag and the evicted page number (zero unless write-back is
// set). Pages are looked up by a scan of the page memory, one slot per
// cycle, pipelined against its registered read. A hit ends the scan;
// a miss while free slots remain takes the next free slot after the full
// scan, and a miss into an empty pool skips the scan. Once the pool is
// full a miss runs a second pass over the age memory (one slot a cycle)
// that ages every slot and finds the oldest, then reads and replaces the
// victim's page. One request is in flight at a time; the next is taken
// as soon as the result sits in the output register, even while it waits
// for m_tready. No clearing pass is needed after reset.
`include "assert_macros.svh"

module page_buffer_pool_replacement (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pbr_pkg::S_DATA_W-1:0] s_tdata,  // [31:0] page_number
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [3:0] slot, [4] hit, [5] writeback, [37:6] evicted_page, [39:38] zero
    output logic [pbr_pkg::M_DATA_W-1:0] m_tdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;
    localparam logic [2:0] ST_MISS  = 3'd2;
    localparam logic [2:0] ST_AGE   = 3'd3;
    localparam logic [2:0] ST_EVICT = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [pbr_pkg::CNT_W-1:0] FULL = pbr_pkg::CNT_W'(pbr_pkg::SLOTS);

    logic [2:0] state_reg, state_next;

    // Page memory, one read and one write port.
    logic [pbr_pkg::PAGE_W-1:0] page_mem [pbr_pkg::SLOTS];
    logic [pbr_pkg::PAGE_W-1:0] page_rd_reg;
    logic [pbr_pkg::SLOT_W-1:0] rd_addr;
    logic                       page_we;
    logic [pbr_pkg::SLOT_W-1:0] page_waddr;

    logic [pbr_pkg::CNT_W-1:0]  filled_reg, filled_next;
    logic [pbr_pkg::PAGE_W-1:0] req_reg, req_next;
    logic                       issue_reg, issue_next;
    logic [pbr_pkg::SLOT_W-1:0] cnt_reg, cnt_next;
    logic                       pv_reg, pv_next;
    logic [pbr_pkg::SLOT_W-1:0] pidx_reg, pidx_next;

    // Result held until the output register frees up.
    logic [pbr_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic                       res_hit_reg, res_hit_next;
    logic                       res_wb_reg, res_wb_next;
    logic [pbr_pkg::PAGE_W-1:0] res_old_reg, res_old_next;

    logic                         m_valid_reg, m_valid_next;
    logic [pbr_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    pbr_pkg::age_cmd_t age_cmd;
    pbr_pkg::age_sts_t age_sts;

    logic s_accept;
    logic out_free;
    logic last_issue;

    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign last_issue = {1'b0, cnt_reg} == (filled_reg - 1'b1);
    assign rd_addr    = (state_reg == ST_AGE) ? age_sts.victim : cnt_reg;

    pbr_age_scan u_age (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (age_cmd),
        .sts     (age_sts)
    );

    always_comb begin
        state_next    = state_reg;
        filled_next   = filled_reg;
        req_next      = req_reg;
        issue_next    = issue_reg;
        cnt_next      = cnt_reg;
        pv_next       = 1'b0;
        pidx_next     = pidx_reg;
        res_slot_next = res_slot_reg;
        res_hit_next  = res_hit_reg;
        res_wb_next   = res_wb_reg;
        res_old_next  = res_old_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        page_we       = 1'b0;
        page_waddr    = filled_reg[pbr_pkg::SLOT_W-1:0];
        age_cmd       = '0;
        age_cmd.fill_idx = filled_reg[pbr_pkg::SLOT_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_next   = s_tdata;
                    cnt_next   = '0;
                    issue_next = 1'b1;
                    state_next = (filled_reg == '0) ? ST_MISS : ST_LOOK;
                end
            end
            ST_LOOK: begin
                // Issue one slot read a cycle; compare in the cycle after.
                if (issue_reg) begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg;
                    if (last_issue) begin
                        issue_next = 1'b0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if (pv_reg) begin
                    if (page_rd_reg == req_reg) begin
                        res_slot_next = pidx_reg;
                        res_hit_next  = 1'b1;
                        res_wb_next   = 1'b0;
                        res_old_next  = '0;
                        issue_next    = 1'b0;
                        pv_next       = 1'b0;
                        state_next    = ST_OUT;
                    end else if ({1'b0, pidx_reg} == (filled_reg - 1'b1)) begin
                        state_next = ST_MISS;
                    end
                end
            end
            ST_MISS: begin
                if (filled_reg < FULL) begin
                    // Take the next free slot at age zero.
                    page_we         = 1'b1;
                    age_cmd.fill_we = 1'b1;
                    filled_next     = filled_reg + 1'b1;
                    res_slot_next   = filled_reg[pbr_pkg::SLOT_W-1:0];
                    res_hit_next    = 1'b0;
                    res_wb_next     = 1'b0;
                    res_old_next    = '0;
                    state_next      = ST_OUT;
                end else begin
                    age_cmd.scan_start = 1'b1;
                    state_next         = ST_AGE;
                end
            end
            ST_AGE: begin
                // Victim is stable once the scan reports done; read its page.
                if (age_sts.done) begin
                    res_slot_next = age_sts.victim;
                    state_next    = ST_EVICT;
                end
            end
            ST_EVICT: begin
                page_we      = 1'b1;
                page_waddr   = res_slot_reg;
                res_hit_next = 1'b0;
                res_wb_next  = 1'b1;
                res_old_next = page_rd_reg;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, res_old_reg, res_wb_reg, res_hit_reg,
                                    pbr_pkg::OSLOT_W'(res_slot_reg)};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (page_we) begin
            page_mem[page_waddr] <= req_reg;
        end
        page_rd_reg <= page_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            filled_reg  <= '0;
            issue_reg   <= 1'b0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            filled_reg  <= filled_next;
            issue_reg   <= issue_next;
            pv_reg      <= pv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        cnt_reg      <= cnt_next;
        pidx_reg     <= pidx_next;
        res_slot_reg <= res_slot_next;
        res_hit_reg  <= res_hit_next;
        res_wb_reg   <= res_wb_next;
        res_old_reg  <= res_old_next;
        m_data_reg   <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `PBR_NEVER(a_fill_bound, aclk, aresetn, filled_reg > FULL)
    `PBR_NEVER(a_hit_no_wb, aclk, aresetn, m_tvalid && m_tdata[4] && m_tdata[5])
    `PBR_ASSERT(a_evict_full, aclk, aresetn, (m_tvalid && m_tdata[5]) |-> (filled_reg == FULL))
    `PBR_ASSERT(a_scan_in_age, aclk, aresetn, age_sts.done |-> (state_reg == ST_AGE))

endmodule

/* tb/sv/testbench.sv */
module testbench;

    // One answer of the buffer pool, in the order the fields sit in m_tdata.
    typedef struct packed {
        logic [pbr_pkg::OSLOT_W-1:0] slot;
        logic                        hit;
        logic                        writeback;
        logic [pbr_pkg::PAGE_W-1:0]  evicted_page;
    } slot_answer_t;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [pbr_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [pbr_pkg::M_DATA_W-1:0] m_tdata;

    // Pages still to be offered on the slave side, and answers still owed.
    logic [pbr_pkg::PAGE_W-1:0] page_requests [$];
    slot_answer_t               slot_answers [$];

    // Own copy of the pool: page and age per slot, and how many are in use.
    logic [pbr_pkg::PAGE_W-1:0] pool_page [pbr_pkg::SLOTS];
    logic [pbr_pkg::AGE_W-1:0]  pool_age [pbr_pkg::SLOTS];
    int                         pool_filled = 0;

    int mismatches     = 0;
    int results_seen   = 0;
    int hits_seen      = 0;
    int fills_seen     = 0;
    int evictions_seen = 0;

    // Handshake pacing: gap before the next page, stall of the result side,
    // and "calm" stretches in which a side does not idle at all.
    int send_gap    = 0;
    int ready_stall = 0;
    bit send_taken  = 1'b0;
    bit calm_in     = 1'b0;
    bit calm_out    = 1'b0;

    page_buffer_pool_replacement dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] page_number
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [3:0] slot, [4] hit, [5] writeback, [37:6] evicted_page
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 60);
    endfunction

    // Look the page up, fill a free slot, or evict the oldest slot (lowest
    // index on a tie); queue the answer the block owes for it.
    task automatic serve_page(input logic [pbr_pkg::PAGE_W-1:0] page);
        slot_answer_t ans;
        int           victim;
        bit           found;
        ans   = '0;
        found = 1'b0;
        for (int i = 0; i < pool_filled; i++) begin
            if (!found && pool_page[i] == page) begin
                ans.slot = pbr_pkg::OSLOT_W'(i);
                ans.hit  = 1'b1;
                found    = 1'b1;
            end
        end
        if (found) begin
            // Hit: ages stay as they are.
            hits_seen++;
        end else if (pool_filled < pbr_pkg::SLOTS) begin
            pool_page[pool_filled] = page;
            pool_age[pool_filled]  = '0;
            ans.slot               = pbr_pkg::OSLOT_W'(pool_filled);
            pool_filled++;
            fills_seen++;
        end else begin
            victim = 0;
            for (int i = 1; i < pbr_pkg::SLOTS; i++) begin
                if (pool_age[i] > pool_age[victim])
                    victim = i;
            end
            // Age every slot, saturating, then restart the victim's age.
            for (int i = 0; i < pbr_pkg::SLOTS; i++) begin
                if (pool_age[i] < pbr_pkg::AGE_MAX)
                    pool_age[i] = pool_age[i] + 1'b1;
            end
            ans.slot          = pbr_pkg::OSLOT_W'(victim);
            ans.writeback     = 1'b1;
            ans.evicted_page  = pool_page[victim];
            pool_age[victim]  = '0;
            pool_page[victim] = page;
            evictions_seen++;
        end
        slot_answers.push_back(ans);
    endtask

    // Slave side, sampled at the rising edge: a transfer feeds the predictor
    // and retires the page from the pending queue.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            serve_page(s_tdata);
            void'(page_requests.pop_front());
            send_taken = 1'b1;
        end
    end

    // Slave side driver, at the falling edge: hold an offered page until it
    // is taken, then wait out its gap and offer the next one.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || send_taken) begin
            send_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (page_requests.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= page_requests[0];
                send_gap = pick_gap(calm_in);
                if ($urandom_range(0, 199) == 0)
                    calm_in = !calm_in;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Master side driver: stall after some transfers, and sometimes out of
    // the blue so that stalls also land while a result is waiting.
    always @(negedge aclk) begin
        if (ready_stall == 0 && !calm_out && $urandom_range(0, 15) == 0)
            ready_stall = $urandom_range(1, 8);
        if (ready_stall > 0) begin
            ready_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Master side monitor: compare each transfer with the oldest answer owed.
    always @(posedge aclk) begin : result_check
        slot_answer_t want;
        bit           bad;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            ready_stall = pick_gap(calm_out);
            if ($urandom_range(0, 199) == 0)
                calm_out = !calm_out;
            if (slot_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: no answer owed, got m_tdata %h",
                             results_seen, m_tdata);
            end else begin
                want = slot_answers.pop_front();
                bad  = (m_tdata[3:0] !== want.slot) || (m_tdata[4] !== want.hit) ||
                       (m_tdata[5] !== want.writeback) ||
                       (m_tdata[37:6] !== want.evicted_page) || (m_tdata[39:38] !== 2'b00);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: want slot %0d hit %0b wb %0b evicted %h, ",
                                  "got slot %0d hit %0b wb %0b evicted %h pad %b"},
                                 results_seen, want.slot, want.hit, want.writeback,
                                 want.evicted_page, m_tdata[3:0], m_tdata[4], m_tdata[5],
                                 m_tdata[37:6], m_tdata[39:38]);
                end
            end
        end
    end

    initial begin : stimulus
        logic [pbr_pkg::PAGE_W-1:0] opening_pages [23];
        logic [pbr_pkg::PAGE_W-1:0] recent_pages [$];
        logic [pbr_pkg::PAGE_W-1:0] page;
        int                         r;

        foreach (pool_age[i])
            pool_age[i] = '0;

        // Two extreme pages, hits on both, fill the rest of the pool, hit the
        // top slot and slot zero, then evict three times: first from all-equal
        // ages (tie goes to slot zero), then by age.
        opening_pages = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h5555_5555,
            32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678,
            32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0002, 32'hFFFF_FFFE,
            32'h3333_3333, 32'hCCCC_CCCC, 32'hCCCC_CCCC, 32'h0000_0000,
            32'h1357_9BDF, 32'h0000_0000, 32'hFFFF_FFFF
        };
        foreach (opening_pages[i])
            page_requests.push_back(opening_pages[i]);

        // Random part: half reuse of recent pages (hits and re-misses after
        // eviction), some tiny page numbers, a few extremes, the rest fresh.
        for (int n = 0; n < 1000; n++) begin
            r = $urandom_range(0, 99);
            if (r < 50 && recent_pages.size() > 0)
                page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
            else if (r < 60)
                page = $urandom_range(0, 31);
            else if (r < 63)
                page = $urandom_range(0, 1) ? '1 : '0;
            else
                page = $urandom();
            page_requests.push_back(page);
            recent_pages.push_back(page);
            if (recent_pages.size() > 24)
                void'(recent_pages.pop_front());
        end

        // Hold reset, then release it at a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: every page taken and every answer seen, then a quiet tail.
        while (page_requests.size() > 0 || slot_answers.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        mismatches += slot_answers.size();
        $display("covered %0d page requests: %0d hits, %0d fills, %0d evictions",
                 results_seen, hits_seen, fills_seen, evictions_seen);
        $display("mismatched or missing results: %0d", mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Stop a hung run well past the slowest legal pace.
    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pbr_pkg.sv
hw/rtl/pbr_age_scan.sv
hw/rtl/page_buffer_pool_replacement.sv
tb/sv/testbench.sv
